### hw/rtl/xmodem_sender_top_assert.svh
// ----------------------------------------------------------------------------
// xmodem sender assertion macros
// shared assertion forms, sampled on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef XMODEM_SENDER_TOP_ASSERT_SVH
`define XMODEM_SENDER_TOP_ASSERT_SVH

// plain property checked at every rising clock edge out of reset
`define XMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define XMS_ASSERT_IMPLY(label, ante, cons, msg) \
   `XMS_ASSERT(label, (ante) |-> (cons), msg)

`endif

### hw/rtl/xms_pkg.sv
// ----------------------------------------------------------------------------
// xmodem sender package
// constants, codes, types and the crc-16 byte update
// ----------------------------------------------------------------------------
package xms_pkg;

   // packet geometry
   localparam int PAYLOAD_BYTES    = 128;
   localparam int ADDR_W           = $clog2(PAYLOAD_BYTES);
   localparam int FRAME_DATA_FIRST = 3;
   localparam int FRAME_CHECK_IDX  = FRAME_DATA_FIRST + PAYLOAD_BYTES;
   localparam int FRAME_LEN_SUM    = FRAME_DATA_FIRST + PAYLOAD_BYTES + 1;
   localparam int FRAME_LEN_CRC    = FRAME_DATA_FIRST + PAYLOAD_BYTES + 2;
   localparam int CNT_W            = $clog2(FRAME_LEN_CRC + 1);

   // field widths
   localparam int CMD_W    = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 8;
   localparam int CRC_W    = 16;

   // line characters
   localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
   localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
   localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
   localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
   localparam logic [BYTE_W-1:0] CH_CAN = 8'h18;
   localparam logic [BYTE_W-1:0] CH_PAD = 8'h1A;
   localparam logic [BYTE_W-1:0] CH_C   = 8'h43;

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
   localparam logic [CFG_W-1:0] START_ATTEMPTS_RST = 8'd6;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LINE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PAYLOAD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SLOT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EOF     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 3'd4;

   // result kinds
   localparam logic KIND_LINE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_ACKED     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_COMPLETE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_RX     = 2'd3;

   // transfer phases
   typedef enum logic [7:0] {
      PH_WAIT_START   = 8'b0000_0001,
      PH_FILL         = 8'b0000_0010,
      PH_SEND         = 8'b0000_0100,
      PH_WAIT_ACK     = 8'b0000_1000,
      PH_SEND_EOT     = 8'b0001_0000,
      PH_WAIT_EOT_ACK = 8'b0010_0000,
      PH_DONE         = 8'b0100_0000,
      PH_ABORTED      = 8'b1000_0000
   } phase_type;

   // one result item
   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   tx_byte;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   packet_number;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } core_res_type;

   // packet buffer write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } mem_wr_type;

   // core status seen by the top level
   typedef struct packed {
      logic             ended;
      logic [CNT_W-1:0] send_idx;
   } core_stat_type;

   // crc-16 ccitt update by one byte, high bit first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### hw/rtl/xms_req_if.sv
// ----------------------------------------------------------------------------
// xmodem sender request channel
// valid/ready channel carrying one command and its byte
// ----------------------------------------------------------------------------
interface xms_req_if;
   import xms_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

### hw/rtl/xms_rsp_if.sv
// ----------------------------------------------------------------------------
// xmodem sender result channel
// valid/ready channel carrying one line byte or status report
// ----------------------------------------------------------------------------
interface xms_rsp_if;
   import xms_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   tx_byte;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   packet_number;

   modport source (output valid, output kind, output tx_byte, output status,
                   output packet_number, input ready);
   modport sink   (input valid, input kind, input tx_byte, input status,
                   input packet_number, output ready);
endinterface

### hw/rtl/xmodem_sender_top.sv
// ----------------------------------------------------------------------------
// xmodem sender top level
// request register, protocol core with packet buffer, result register
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req_chan  in   valid/ready   cmd[2:0], value[7:0]
//  rsp_chan  out  valid/ready   kind, tx_byte[7:0], status[1:0], packet_number[7:0]
//  csr_*     in   write enable  csr_wr_data[7:0] = start attempts
//
//  one request per cycle sustained while rsp_chan.ready holds; a result is offered
//  once its request has passed the request register and then the result register
//  the packet buffer read is prefetched from the next send index
//  reset clears all control state; the 128-byte buffer is not cleared
//  a stalled result holds the result register; one more request is taken
//  into the request register before req_chan.ready drops
// ----------------------------------------------------------------------------
`include "xmodem_sender_top_assert.svh"

module xmodem_sender_top (
   input  logic                       clock,
   input  logic                       reset,
   xms_req_if.sink                    req_chan,
   xms_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [xms_pkg::CFG_W-1:0]  csr_wr_data
);
   import xms_pkg::*;

   logic              in_vld_ff, in_vld_in;
   logic [CMD_W-1:0]  in_cmd_ff;
   logic [BYTE_W-1:0] in_val_ff;
   logic              out_vld_ff, out_vld_in;
   rsp_item_type      out_item_ff;
   logic              fire;

   mem_wr_type        mem_wr;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   core_res_type      res;
   core_stat_type     stat;

   // request moves on when the result register is free or draining
   assign fire           = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || fire;
   assign in_vld_in      = req_chan.ready ? req_chan.valid : in_vld_ff;
   assign out_vld_in     = fire ? res.valid : (out_vld_ff && !rsp_chan.ready);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_chan.ready) begin
         in_cmd_ff <= req_chan.cmd;
         in_val_ff <= req_chan.value;
      end
   end

   xms_pkt_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   xms_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (fire),
      .item_cmd    (in_cmd_ff),
      .item_value  (in_val_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rd_data     (rd_data),
      .mem_wr      (mem_wr),
      .rd_addr     (rd_addr),
      .res         (res),
      .stat        (stat)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (fire) begin
         out_item_ff <= res.item;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.kind          = out_item_ff.kind;
   assign rsp_chan.tx_byte       = out_item_ff.tx_byte;
   assign rsp_chan.status        = out_item_ff.status;
   assign rsp_chan.packet_number = out_item_ff.packet_number;

   // checks
   `XMS_ASSERT_IMPLY(a_stall_only_on_rsp, !req_chan.ready, out_vld_ff && !rsp_chan.ready,
      "request stalled without a pending result")
   `XMS_ASSERT_IMPLY(a_quiet_when_ended, stat.ended, !res.valid,
      "result produced after the transfer ended")
   `XMS_ASSERT_IMPLY(a_line_byte_status, rsp_chan.valid && rsp_chan.kind == KIND_LINE,
      rsp_chan.status == ST_ACKED, "line byte result with nonzero status")
   `XMS_ASSERT(a_send_idx_range, stat.send_idx < CNT_W'(FRAME_LEN_CRC),
      "send index beyond the frame")
endmodule

### hw/rtl/xms_pkt_mem.sv
// ----------------------------------------------------------------------------
// xmodem sender packet buffer
// one write port, one registered read port
// ----------------------------------------------------------------------------
module xms_pkt_mem (
   input  logic                          clock,
   input  xms_pkg::mem_wr_type           wr,
   input  logic [xms_pkg::ADDR_W-1:0]    rd_addr,
   output logic [xms_pkg::BYTE_W-1:0]    rd_data
);
   import xms_pkg::*;

   logic [BYTE_W-1:0] mem_ff [PAYLOAD_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/xms_core.sv
// ----------------------------------------------------------------------------
// xmodem sender protocol core
// transfer phases, packet framing, checksum and crc, retry counting
// ----------------------------------------------------------------------------
module xms_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_fire,
   input  logic [xms_pkg::CMD_W-1:0]     item_cmd,
   input  logic [xms_pkg::BYTE_W-1:0]    item_value,
   input  logic                          csr_wr_en,
   input  logic [xms_pkg::CFG_W-1:0]     csr_wr_data,
   input  logic [xms_pkg::BYTE_W-1:0]    rd_data,
   output xms_pkg::mem_wr_type           mem_wr,
   output logic [xms_pkg::ADDR_W-1:0]    rd_addr,
   output xms_pkg::core_res_type         res,
   output xms_pkg::core_stat_type        stat
);
   import xms_pkg::*;

   phase_type         phase_ff, phase_in, phase_mid;
   logic [CNT_W-1:0]  fill_ff, fill_in, fill_mid;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  send_idx_ff, send_idx_in, send_idx_mid;
   logic [BYTE_W-1:0] seq_ff, seq_in;
   logic              use_crc_ff, use_crc_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [CFG_W-1:0]  tries_ff, tries_in;
   logic              end_ff, end_in, end_mid;

   logic              ended;
   logic [CNT_W-1:0]  data_pos;
   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  frame_len;
   logic [CNT_W-1:0]  rd_pos;
   logic [BYTE_W-1:0] data_byte;

   assign ended     = (phase_ff == PH_DONE) || (phase_ff == PH_ABORTED);
   assign data_pos  = send_idx_ff - CNT_W'(FRAME_DATA_FIRST);
   assign idx_next  = send_idx_ff + CNT_W'(1);
   assign frame_len = use_crc_ff ? CNT_W'(FRAME_LEN_CRC) : CNT_W'(FRAME_LEN_SUM);

   // bytes past the stored length are padding
   assign data_byte = (data_pos < len_ff) ? rd_data : CH_PAD;

   // item processing
   always_comb begin
      phase_mid    = phase_ff;
      fill_mid     = fill_ff;
      end_mid      = end_ff;
      send_idx_mid = send_idx_ff;
      seq_in       = seq_ff;
      use_crc_in   = use_crc_ff;
      crc_in       = crc_ff;
      sum_in       = sum_ff;
      tries_in     = tries_ff;

      res.valid              = 1'b0;
      res.item.kind          = KIND_LINE;
      res.item.tx_byte       = '0;
      res.item.status        = ST_ACKED;
      res.item.packet_number = seq_ff;

      mem_wr.en   = 1'b0;
      mem_wr.addr = fill_ff[ADDR_W-1:0];
      mem_wr.data = item_value;

      if (item_fire && !ended) begin
         unique case (item_cmd)
            CMD_LINE, CMD_TIMEOUT: begin
               priority if (phase_ff == PH_WAIT_START) begin
                  priority if (item_cmd == CMD_LINE &&
                               (item_value == CH_C || item_value == CH_NAK)) begin
                     use_crc_in = (item_value == CH_C);
                     phase_mid  = PH_FILL;
                  end else if (tries_ff <= CFG_W'(1)) begin
                     tries_in        = '0;
                     phase_mid       = PH_ABORTED;
                     res.valid       = 1'b1;
                     res.item.kind   = KIND_STATUS;
                     res.item.status = ST_NO_RX;
                  end else begin
                     tries_in = tries_ff - CFG_W'(1);
                  end
               end else if (phase_ff == PH_WAIT_ACK) begin
                  // timeouts and stray bytes are ignored here
                  if (item_cmd == CMD_LINE) begin
                     priority if (item_value == CH_ACK) begin
                        res.valid       = 1'b1;
                        res.item.kind   = KIND_STATUS;
                        res.item.status = ST_ACKED;
                        seq_in          = seq_ff + BYTE_W'(1);
                        fill_mid        = '0;
                        phase_mid       = PH_FILL;
                     end else if (item_value == CH_NAK) begin
                        send_idx_mid = '0;
                        phase_mid    = PH_SEND;
                     end else if (item_value == CH_CAN) begin
                        res.valid       = 1'b1;
                        res.item.kind   = KIND_STATUS;
                        res.item.status = ST_CANCELLED;
                        phase_mid       = PH_ABORTED;
                     end else begin
                     end
                  end
               end else if (phase_ff == PH_WAIT_EOT_ACK) begin
                  if (item_cmd == CMD_LINE && item_value == CH_ACK) begin
                     res.valid       = 1'b1;
                     res.item.kind   = KIND_STATUS;
                     res.item.status = ST_COMPLETE;
                     phase_mid       = PH_DONE;
                  end else begin
                     phase_mid = PH_SEND_EOT;
                  end
               end else begin
               end
            end
            CMD_PAYLOAD: begin
               if ((phase_ff == PH_WAIT_START || phase_ff == PH_FILL) && !end_ff &&
                   fill_ff < CNT_W'(PAYLOAD_BYTES)) begin
                  mem_wr.en = 1'b1;
                  fill_mid  = fill_ff + CNT_W'(1);
               end
            end
            CMD_SLOT: begin
               if (phase_ff == PH_SEND) begin
                  res.valid = 1'b1;
                  priority if (send_idx_ff == '0) begin
                     crc_in           = '0;
                     sum_in           = '0;
                     res.item.tx_byte = CH_SOH;
                  end else if (send_idx_ff == CNT_W'(1)) begin
                     res.item.tx_byte = seq_ff;
                  end else if (send_idx_ff == CNT_W'(2)) begin
                     res.item.tx_byte = ~seq_ff;
                  end else if (send_idx_ff < CNT_W'(FRAME_CHECK_IDX)) begin
                     crc_in           = crc_byte(crc_ff, data_byte);
                     sum_in           = sum_ff + data_byte;
                     res.item.tx_byte = data_byte;
                  end else if (send_idx_ff == CNT_W'(FRAME_CHECK_IDX)) begin
                     res.item.tx_byte = use_crc_ff ? crc_ff[CRC_W-1:BYTE_W] : sum_ff;
                  end else begin
                     res.item.tx_byte = crc_ff[BYTE_W-1:0];
                  end
                  // frame end: wait for the receiver's reply
                  if (idx_next >= frame_len) begin
                     phase_mid    = PH_WAIT_ACK;
                     send_idx_mid = '0;
                  end else begin
                     send_idx_mid = idx_next;
                  end
               end else if (phase_ff == PH_SEND_EOT) begin
                  res.valid        = 1'b1;
                  res.item.tx_byte = CH_EOT;
                  phase_mid        = PH_WAIT_EOT_ACK;
               end else begin
               end
            end
            CMD_EOF: begin
               end_mid = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // start a packet or the end sequence when due
      phase_in    = phase_mid;
      fill_in     = fill_mid;
      len_in      = len_ff;
      send_idx_in = send_idx_mid;
      end_in      = end_mid;
      if (item_fire && phase_mid == PH_FILL) begin
         priority if (fill_mid >= CNT_W'(PAYLOAD_BYTES) ||
                      (end_mid && fill_mid != '0)) begin
            len_in      = fill_mid;
            fill_in     = CNT_W'(PAYLOAD_BYTES);
            send_idx_in = '0;
            phase_in    = PH_SEND;
         end else if (end_mid) begin
            phase_in = PH_SEND_EOT;
         end else begin
         end
      end

      // attempts register write
      if (csr_wr_en) begin
         if (phase_ff == PH_WAIT_START) begin
            tries_in = csr_wr_data;
         end
      end
   end

   // prefetch the data byte for the next send index
   assign rd_pos  = send_idx_in - CNT_W'(FRAME_DATA_FIRST);
   assign rd_addr = rd_pos[ADDR_W-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_START;
         fill_ff     <= '0;
         len_ff      <= '0;
         send_idx_ff <= '0;
         seq_ff      <= BYTE_W'(1);
         use_crc_ff  <= 1'b0;
         crc_ff      <= '0;
         sum_ff      <= '0;
         tries_ff    <= START_ATTEMPTS_RST;
         end_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         send_idx_ff <= send_idx_in;
         seq_ff      <= seq_in;
         use_crc_ff  <= use_crc_in;
         crc_ff      <= crc_in;
         sum_ff      <= sum_in;
         tries_ff    <= tries_in;
         end_ff      <= end_in;
      end
   end

   assign stat.ended    = ended;
   assign stat.send_idx = send_idx_ff;
endmodule
